// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a given clock and active-low reset.
`define TBCR_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Concurrent check on the block clock and reset.
`define TBCR_ASSERT(lbl, prop, msg) `TBCR_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== hdl/tbcr_pkg.sv =====
package tbcr_pkg;

	localparam logic [3:0] EV_NONE             = 4'd0;
	localparam logic [3:0] EV_HOLD_START       = 4'd2;
	localparam logic [3:0] EV_HOLD_END         = 4'd3;
	localparam logic [3:0] EV_CLICK_HOLD_START = 4'd4;
	localparam logic [3:0] EV_CLICK_HOLD_END   = 4'd5;
	localparam logic [3:0] EV_MAX              = 4'd8;

	localparam logic [1:0] LAMP_ONE   = 2'd0;
	localparam logic [1:0] LAMP_TWO   = 2'd1;
	localparam logic [1:0] LAMP_THREE = 2'd2;

	localparam logic [15:0] WINDOW_RESET = 16'd300;

	localparam int MAX_ACTS    = 4;
	localparam int ACT_IDX_W   = $clog2(MAX_ACTS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [3:0]  first_button_event;
		logic [3:0]  second_button_event;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [1:0] target_lamp;
		logic [3:0] action_event;
		logic       last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [1:0] lamp;
		logic [3:0] ev;
	} action_t;

	// All actions caused by one input word; last_idx is the count minus one.
	typedef struct packed {
		logic [ACT_IDX_W-1:0]        last_idx;
		action_t [MAX_ACTS-1:0]      acts;
	} bundle_t;

	typedef struct packed {
		logic hold_armed;
		logic pending_any;
	} front_stat_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [3:0] clean_event(input logic [3:0] e);
		return (e > EV_MAX) ? EV_NONE : e;
	endfunction

	function automatic logic starts_hold(input logic [3:0] e);
		return (e == EV_HOLD_START) || (e == EV_CLICK_HOLD_START);
	endfunction

	function automatic logic ends_hold(input logic [3:0] e);
		return (e == EV_HOLD_END) || (e == EV_CLICK_HOLD_END);
	endfunction

endpackage

// ===== hdl/two_button_combo_router.sv =====
// Two-button combination router. Each input word carries one gesture event per
// button and a millisecond timestamp; each output word is one action for lamp
// one, lamp two or the combined lamp three, with last_of_run set on the final
// action caused by an input word. The front end classifies an input word
// combinationally and takes a new one every cycle while its two-entry action
// queue has room. The result port then delivers one action per cycle while
// out_ready is high, so an input word that causes k actions (at most four)
// gives k output words, and a word that causes none pushes nothing. The result
// port's one-action-per-cycle drain sets the sustained rate. The window
// register may be rewritten at any cycle while no word is in flight.
`include "assert_macros.svh"

module two_button_combo_router import tbcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);

	logic        accept, push, pop;
	bundle_t     push_data, head;
	front_stat_t fstat;
	queue_stat_t qstat;

	assign cfg_ready = 1'b1;
	assign in_ready  = !qstat.full;
	assign accept    = in_valid && in_ready;

	tbcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_data   (in_data),
		.push      (push),
		.bundle    (push_data),
		.stat      (fstat)
	);

	tbcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	tbcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`TBCR_ASSERT(a_no_push_full, qstat.full |-> !push, "push into a full action queue")
	`TBCR_ASSERT(a_hold_pending, fstat.hold_armed |-> fstat.pending_any, "hold without pending end")
	`TBCR_ASSERT(a_run_continues, (out_valid && out_ready && !out_data.last_of_run) |=> out_valid, "gap inside a run of actions")
	`TBCR_ASSERT(a_pop_not_empty, pop |-> !qstat.empty, "pop from an empty action queue")

endmodule

// ===== hdl/tbcr_front.sv =====
module tbcr_front import tbcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	input  logic        accept,
	input  in_word_t    in_data,
	output logic        push,
	output bundle_t     bundle,
	output front_stat_t stat
);

	logic [15:0] window_q;
	logic [3:0]  pend_first_q, pend_second_q;
	logic [31:0] win_start_q;
	logic        win_active_q, combo_hold_q;

	logic [3:0]  pend_first_d, pend_second_d;
	logic [31:0] win_start_d;
	logic        win_active_d, combo_hold_d;

	logic [3:0]  e1, e2, fin, pair_ev;
	logic [31:0] elapsed;
	logic [ACT_IDX_W:0] n;
	action_t [MAX_ACTS-1:0] acts;

	always_comb begin
		e1            = clean_event(in_data.first_button_event);
		e2            = clean_event(in_data.second_button_event);
		pend_first_d  = pend_first_q;
		pend_second_d = pend_second_q;
		win_start_d   = win_start_q;
		win_active_d  = win_active_q;
		combo_hold_d  = combo_hold_q;
		fin           = EV_NONE;
		pair_ev       = EV_NONE;
		elapsed       = '0;
		n             = '0;
		acts          = '0;

		if (combo_hold_q) begin
			if (ends_hold(e1) && e1 == pend_first_d) begin
				fin          = e1;
				pend_first_d = EV_NONE;
			end
			if (ends_hold(e2) && e2 == pend_second_d) begin
				fin           = e2;
				pend_second_d = EV_NONE;
			end
			if (pend_first_d == EV_NONE && pend_second_d == EV_NONE) begin
				if (fin != EV_NONE) begin
					acts[n[ACT_IDX_W-1:0]] = '{lamp: LAMP_THREE, ev: fin};
					n = n + 1'b1;
				end
				win_start_d  = '0;
				win_active_d = 1'b0;
				combo_hold_d = 1'b0;
			end
		end else begin
			if (e1 != EV_NONE) begin
				if (!win_active_d) begin
					win_active_d = 1'b1;
					win_start_d  = in_data.now_ms;
				end
				if (pend_first_d != EV_NONE) begin
					acts[n[ACT_IDX_W-1:0]] = '{lamp: LAMP_ONE, ev: pend_first_d};
					n = n + 1'b1;
				end
				pend_first_d = e1;
			end
			if (e2 != EV_NONE) begin
				if (!win_active_d) begin
					win_active_d = 1'b1;
					win_start_d  = in_data.now_ms;
				end
				if (pend_second_d != EV_NONE) begin
					acts[n[ACT_IDX_W-1:0]] = '{lamp: LAMP_TWO, ev: pend_second_d};
					n = n + 1'b1;
				end
				pend_second_d = e2;
			end
			// Elapsed time wraps modulo 2^32 like the timestamp counter.
			elapsed = in_data.now_ms - win_start_d;
			if (win_active_d) begin
				if (elapsed > {16'd0, window_q}) begin
					if (pend_first_d != EV_NONE) begin
						acts[n[ACT_IDX_W-1:0]] = '{lamp: LAMP_ONE, ev: pend_first_d};
						n = n + 1'b1;
					end
					if (pend_second_d != EV_NONE) begin
						acts[n[ACT_IDX_W-1:0]] = '{lamp: LAMP_TWO, ev: pend_second_d};
						n = n + 1'b1;
					end
					pend_first_d  = EV_NONE;
					pend_second_d = EV_NONE;
					win_start_d   = '0;
					win_active_d  = 1'b0;
				end else if (pend_first_d != EV_NONE && pend_first_d == pend_second_d) begin
					pair_ev = pend_first_d;
					acts[n[ACT_IDX_W-1:0]] = '{lamp: LAMP_THREE, ev: pair_ev};
					n = n + 1'b1;
					pend_first_d  = EV_NONE;
					pend_second_d = EV_NONE;
					win_start_d   = '0;
					win_active_d  = 1'b0;
					// A matching hold start waits for both matching hold ends.
					if (starts_hold(pair_ev)) begin
						combo_hold_d  = 1'b1;
						pend_first_d  = (pair_ev == EV_HOLD_START) ? EV_HOLD_END
						                                            : EV_CLICK_HOLD_END;
						pend_second_d = pend_first_d;
					end
				end
			end
		end
	end

	assign push            = accept && (n != '0);
	assign bundle.acts     = acts;
	assign bundle.last_idx = ACT_IDX_W'(n - 1'b1);
	assign stat.hold_armed    = combo_hold_q;
	assign stat.pending_any   = (pend_first_q != EV_NONE) || (pend_second_q != EV_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= WINDOW_RESET;
			pend_first_q  <= EV_NONE;
			pend_second_q <= EV_NONE;
			win_start_q   <= '0;
			win_active_q  <= 1'b0;
			combo_hold_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (accept) begin
				pend_first_q  <= pend_first_d;
				pend_second_q <= pend_second_d;
				win_start_q   <= win_start_d;
				win_active_q  <= win_active_d;
				combo_hold_q  <= combo_hold_d;
			end
		end
	end

endmodule

// ===== hdl/tbcr_queue.sv =====
module tbcr_queue import tbcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bundle_t     push_data,
	input  logic        pop,
	output bundle_t     head,
	output queue_stat_t stat
);

	bundle_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'((wr_ptr_q + 1'b1) % QUEUE_DEPTH);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'((rd_ptr_q + 1'b1) % QUEUE_DEPTH);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/tbcr_back.sv =====
module tbcr_back import tbcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  queue_stat_t qstat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);

	logic [ACT_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	out_word_t            out_data_q;
	logic                 load, take, is_last;
	action_t              cur;

	// The output register reloads whenever it is empty or being taken.
	assign load    = !out_valid_q || out_ready;
	assign take    = load && !qstat.empty;
	assign cur     = head.acts[idx_q];
	assign is_last = (idx_q == head.last_idx);
	assign pop     = take && is_last;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q.target_lamp  <= cur.lamp;
			out_data_q.action_event <= cur.ev;
			out_data_q.last_of_run  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !qstat.empty;
			end
			if (take) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
		end
	end

endmodule
